FILE: rtl/core/tsf_pkg.sv
// Shared constants and types for the touch sample filter.
package tsf_pkg;

   // Group layout and sample format
   localparam int SAMPLES_PER_GROUP = 5;
   localparam int DROP_EACH_END     = 1;
   localparam int RAW_W             = 16;
   localparam int SAMPLE_W          = 12;
   localparam int SAMPLE_LSB        = 4;
   localparam int POS_W             = $clog2(SAMPLES_PER_GROUP);
   localparam int LAST_POS          = SAMPLES_PER_GROUP - 1;

   // Samples kept after trimming both ends of the sorted group
   localparam int KEPT = (2 * DROP_EACH_END >= SAMPLES_PER_GROUP) ? 0 :
                         SAMPLES_PER_GROUP - 2 * DROP_EACH_END;

   // Sum of kept samples and reciprocal for the floor mean
   localparam int SUM_W     = 16;
   localparam int DIV_SHIFT = 20;
   localparam int RECIP_W   = 21;
   localparam int RECIP     = (KEPT == 0) ? 0 : ((1 << DIV_SHIFT) + KEPT - 1) / KEPT;
   localparam int PROD_W    = SUM_W + RECIP_W;

   localparam logic [SAMPLE_W-1:0] MATCH_LIMIT_RESET = 12'd50;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // Data handed from one sort cell to the next
   typedef struct packed {
      logic       less;
      logic       valid;
      sample_type value;
   } cell_link_type;

   // Position of a group within the sequence
   typedef enum logic [1:0] {
      GRP_X_FIRST,
      GRP_Y_FIRST,
      GRP_X_SECOND,
      GRP_Y_SECOND
   } group_type;

   // Finished group mean with its tag
   typedef struct packed {
      logic       done;
      group_type  grp;
      sample_type mean;
   } mean_out_type;

endpackage

FILE: rtl/core/touch_sample_filter_top.sv
// Top level of the touch sample filter: sort chain, mean unit and result stage.
// Throughput: one raw word per cycle when not held off; a sequence is twenty words
// (X, Y, X, Y groups). The result word is registered after the sort chain update,
// the sum register, the reciprocal multiply register, then the result register.
// The last word of a sequence is held off only while the previous result is unclaimed.
// Reset is synchronous: counters, means and output valid clear, match limit returns to 50.
module touch_sample_filter_top
   import tsf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [RAW_W-1:0]    req_tdata,   // [15:0] raw_word
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // [11:0] x_coord, [23:12] y_coord
   output logic                rsp_tuser,   // [0] valid_res
   input  logic                csr_wr_en,
   input  logic [SAMPLE_W-1:0] csr_wr_data  // [11:0] match limit
);

   logic          req_accept;
   logic          pos_last;
   logic          start;
   sample_type    sample;
   logic [POS_W-1:0] pos_ff, pos_in;
   group_type     grp_ff, grp_in;
   logic          done_ff;
   group_type     done_grp_ff;
   sample_type    match_limit_ff;
   cell_link_type links [SAMPLES_PER_GROUP+1];
   sample_type    sorted [SAMPLES_PER_GROUP];
   mean_out_type  mean_out;
   sample_type    fx_ff, fy_ff, sx_ff;
   sample_type    dx, dy;
   logic [SAMPLE_W:0] sum_x, sum_y;
   logic          agree;
   logic          rsp_valid_ff, rsp_valid_in;
   sample_type    rsp_x_ff, rsp_y_ff;
   logic          rsp_ok_ff;
   logic          load_rsp;

   assign sample     = req_tdata[SAMPLE_LSB +: SAMPLE_W];
   assign pos_last   = (pos_ff == POS_W'(LAST_POS));
   assign start      = (pos_ff == '0);
   // hold the closing word while a result still waits
   assign req_tready = !(pos_last && grp_ff == GRP_Y_SECOND && rsp_valid_ff);
   assign req_accept = req_tvalid && req_tready;

   // Advance position within group and group within sequence
   always_comb begin
      pos_in = pos_ff;
      grp_in = grp_ff;
      if (req_accept) begin
         if (pos_last) begin
            pos_in = '0;
            grp_in = group_type'(grp_ff + 2'd1);
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         grp_ff         <= GRP_X_FIRST;
         done_ff        <= 1'b0;
         match_limit_ff <= MATCH_LIMIT_RESET;
      end else begin
         pos_ff  <= pos_in;
         grp_ff  <= grp_in;
         done_ff <= req_accept && pos_last;
         if (csr_wr_en) begin
            match_limit_ff <= csr_wr_data;
         end
      end
      if (req_accept && pos_last) begin
         done_grp_ff <= grp_ff;
      end
   end

   // Sort chain
   assign links[0] = '{less: 1'b0, valid: 1'b0, value: '0};

   for (genvar i = 0; i < SAMPLES_PER_GROUP; i++) begin : g_cell
      tsf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (req_accept),
         .start    (start),
         .sample   (sample),
         .link_i   (links[i]),
         .link_o   (links[i+1])
      );
      assign sorted[i] = links[i+1].value;
   end

   tsf_mean u_mean (
      .clock    (clock),
      .reset    (reset),
      .done_i   (done_ff),
      .grp_i    (done_grp_ff),
      .sorted_i (sorted),
      .mean_o   (mean_out)
   );

   // Compare the two readings of each axis and average them
   assign dx    = (fx_ff >= sx_ff) ? fx_ff - sx_ff : sx_ff - fx_ff;
   assign dy    = (fy_ff >= mean_out.mean) ? fy_ff - mean_out.mean : mean_out.mean - fy_ff;
   assign agree = (dx < match_limit_ff) && (dy < match_limit_ff);
   assign sum_x = {1'b0, fx_ff} + {1'b0, sx_ff};
   assign sum_y = {1'b0, fy_ff} + {1'b0, mean_out.mean};

   assign load_rsp = mean_out.done && (mean_out.grp == GRP_Y_SECOND);

   // Output word: set on a finished sequence, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff        <= '0;
         fy_ff        <= '0;
         sx_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (mean_out.done) begin
            case (mean_out.grp)
               GRP_X_FIRST:  fx_ff <= mean_out.mean;
               GRP_Y_FIRST:  fy_ff <= mean_out.mean;
               GRP_X_SECOND: sx_ff <= mean_out.mean;
               default:      ;
            endcase
         end
      end
      if (load_rsp) begin
         rsp_ok_ff <= agree;
         rsp_x_ff  <= agree ? sum_x[SAMPLE_W:1] : '0;
         rsp_y_ff  <= agree ? sum_y[SAMPLE_W:1] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_ok_ff;

   // Input is only held off by a pending result
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_valid_ff)
      else $error("input stalled without a pending result");

   // A new result never lands on one that is still waiting
   assert property (@(posedge clock) disable iff (reset) load_rsp |-> !rsp_valid_ff)
      else $error("result overwritten before it was taken");

   // A rejected result carries zero coordinates
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_x_ff == '0 && rsp_y_ff == '0))
      else $error("rejected result with non-zero coordinates");

   // Position stays inside the group
   assert property (@(posedge clock) disable iff (reset) pos_ff <= POS_W'(LAST_POS))
      else $error("group position out of range");

   // Occupied cells stay packed and ascending
   for (genvar i = 1; i < SAMPLES_PER_GROUP; i++) begin : g_sort_chk
      assert property (@(posedge clock) disable iff (reset)
         links[i+1].valid |-> (links[i].valid && links[i].value <= links[i+1].value))
         else $error("sort chain out of order");
   end

endmodule

FILE: rtl/core/tsf_cell.sv
// One cell of the insertion sort chain: holds one sample of the group in order.
module tsf_cell
   import tsf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          shift_en,
   input  logic          start,
   input  sample_type    sample,
   input  cell_link_type link_i,
   output cell_link_type link_o
);

   sample_type value_ff, value_in;
   logic       valid_ff, valid_in;
   logic       less;

   // Treat an empty cell, or every cell on a new group, as larger than the new sample
   assign less = start || !valid_ff || (sample < value_ff);

   assign link_o = '{less: less, valid: valid_ff && !start, value: value_ff};

   // Take the left neighbour's entry if it also moves up, else take the new sample
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (shift_en && less) begin
         if (link_i.less) begin
            value_in = link_i.value;
            valid_in = link_i.valid;
         end else begin
            value_in = sample;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule

FILE: rtl/core/tsf_mean.sv
// Trimmed floor mean of a sorted group: sum stage, then reciprocal multiply stage.
module tsf_mean
   import tsf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         done_i,
   input  group_type    grp_i,
   input  sample_type   sorted_i [SAMPLES_PER_GROUP],
   output mean_out_type mean_o
);

   logic [SUM_W-1:0]  sum_in, sum_ff;
   logic              done1_ff;
   group_type         grp1_ff;
   logic [PROD_W-1:0] prod;
   mean_out_type      mean_ff;

   // Add the samples left after trimming both ends
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < SAMPLES_PER_GROUP; i++) begin
         if (i >= DROP_EACH_END && i < SAMPLES_PER_GROUP - DROP_EACH_END) begin
            sum_in = sum_in + SUM_W'(sorted_i[i]);
         end
      end
   end

   // Divide by the kept count through its reciprocal
   assign prod = PROD_W'(sum_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         done1_ff     <= 1'b0;
         mean_ff.done <= 1'b0;
      end else begin
         done1_ff     <= done_i;
         mean_ff.done <= done1_ff;
      end
      if (done_i) begin
         sum_ff  <= sum_in;
         grp1_ff <= grp_i;
      end
      if (done1_ff) begin
         mean_ff.grp  <= grp1_ff;
         mean_ff.mean <= prod[DIV_SHIFT +: SAMPLE_W];
      end
   end

   assign mean_o = mean_ff;

endmodule
